### rtl/core/aaef_pkg.sv
// Shared types, constants and helper functions of the elementary stream framer.
package aaef_pkg;

  localparam int PS_DEPTH_DEF = 63;

  // Configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_CHANNEL     = 2'd1;
  localparam logic [1:0] CFG_PS_LENGTH   = 2'd2;

  localparam logic [16:0] RATE_RESET    = 17'd44100;
  localparam logic [2:0]  CHANNEL_RESET = 3'd2;

  localparam logic        OP_PAYLOAD = 1'b0;
  localparam logic        OP_LOAD    = 1'b1;

  localparam logic [5:0]  ADTS_LEN   = 6'd7;
  localparam logic [12:0] ADTS_EXTRA = 13'd7;

  localparam logic [7:0] START_ZERO = 8'h00;
  localparam logic [7:0] START_ONE  = 8'h01;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PS_RD,
    ST_PS_OUT,
    ST_HDR,
    ST_BODY
  } aaef_state_e;

  typedef enum logic [1:0] {
    PUSH_NONE,
    PUSH_PS,
    PUSH_ADTS,
    PUSH_BODY
  } aaef_push_e;

  typedef struct packed {
    logic       latch;
    logic       wr_store;
    logic       rd_store;
    aaef_push_e push_sel;
    logic       use_latched;
  } aaef_cmd_t;

  typedef struct packed {
    logic in_op;
    logic in_first;
    logic in_video;
    logic in_key;
    logic ps_empty;
    logic ps_at_end;
    logic hdr_at_end;
    logic slot_free;
  } aaef_sts_t;

  // ADTS sampling frequency index; rates outside the table map to 0
  function automatic logic [3:0] rate_index(input logic [16:0] hz);
    logic [3:0] fi;
    unique case (hz)
      17'd96000: fi = 4'd0;
      17'd88200: fi = 4'd1;
      17'd64000: fi = 4'd2;
      17'd48000: fi = 4'd3;
      17'd44100: fi = 4'd4;
      17'd32000: fi = 4'd5;
      17'd24000: fi = 4'd6;
      17'd22050: fi = 4'd7;
      17'd16000: fi = 4'd8;
      17'd12000: fi = 4'd9;
      17'd11025: fi = 4'd10;
      17'd8000:  fi = 4'd11;
      17'd7350:  fi = 4'd12;
      default:   fi = 4'd0;
    endcase
    return fi;
  endfunction

  // One byte of the 7-byte AAC-LC ADTS header, no CRC
  function automatic logic [7:0] adts_byte(input logic [2:0]  idx,
                                           input logic [3:0]  fi,
                                           input logic [2:0]  ch,
                                           input logic [12:0] flen);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'hFF;
      3'd1:    b = 8'hF1;
      3'd2:    b = {2'b01, fi, 1'b0, ch[2]};
      3'd3:    b = {ch[1:0], 4'b0000, flen[12:11]};
      3'd4:    b = flen[10:3];
      3'd5:    b = {flen[2:0], 5'h1F};
      3'd6:    b = 8'hFC;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/aaef_ctrl.sv
// Sequencer of the framer: accepts items and orders header and payload transfers.
module aaef_ctrl
  import aaef_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  aaef_sts_t sts_i,
  output aaef_cmd_t cmd_o,
  output logic      in_stall_o
);

  aaef_state_e state_q, state_d;
  logic        accept;

  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.slot_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (sts_i.in_op == OP_PAYLOAD) && sts_i.in_first) begin
          if (!sts_i.in_video) begin
            state_d = ST_HDR;
          end else if (sts_i.in_key && !sts_i.ps_empty) begin
            state_d = ST_PS_RD;
          end
        end
      end
      ST_PS_RD: state_d = ST_PS_OUT;
      ST_PS_OUT: begin
        if (sts_i.slot_free) begin
          state_d = sts_i.ps_at_end ? ST_BODY : ST_PS_RD;
        end
      end
      ST_HDR: begin
        if (sts_i.slot_free && sts_i.hdr_at_end) begin
          state_d = ST_BODY;
        end
      end
      ST_BODY: begin
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{latch: 1'b0, wr_store: 1'b0, rd_store: 1'b0,
              push_sel: PUSH_NONE, use_latched: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.in_op == OP_LOAD) begin
            cmd_o.wr_store = 1'b1;
          end else if (sts_i.in_first &&
                       (!sts_i.in_video || (sts_i.in_key && !sts_i.ps_empty))) begin
            cmd_o.latch = 1'b1;
          end else begin
            cmd_o.push_sel = PUSH_BODY;
          end
        end
      end
      ST_PS_RD: cmd_o.rd_store = 1'b1;
      ST_PS_OUT: begin
        if (sts_i.slot_free) begin
          cmd_o.push_sel = PUSH_PS;
        end
      end
      ST_HDR: begin
        if (sts_i.slot_free) begin
          cmd_o.push_sel = PUSH_ADTS;
        end
      end
      ST_BODY: begin
        cmd_o.use_latched = 1'b1;
        if (sts_i.slot_free) begin
          cmd_o.push_sel = PUSH_BODY;
        end
      end
      default: cmd_o.push_sel = PUSH_NONE;
    endcase
  end

endmodule

### rtl/core/aaef_dp.sv
// Datapath of the framer: config, parameter-set store, prefix parser, output register.
module aaef_dp
  import aaef_pkg::*;
#(
  parameter int PARAM_SET_DEPTH = PS_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  store_index_i,
  input  logic        sample_first_i,
  input  logic        sample_last_i,
  input  logic        is_video_i,
  input  logic        is_key_i,
  input  logic [12:0] sample_size_i,
  input  logic        out_stall_i,
  input  aaef_cmd_t   cmd_i,
  output aaef_sts_t   sts_o,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        sample_done_o,
  output logic        malformed_o
);

  localparam int AW = $clog2(PARAM_SET_DEPTH);
  localparam logic [5:0] DEPTH6 = 6'(PARAM_SET_DEPTH);

  // configuration
  logic [16:0] rate_q;
  logic [2:0]  chan_q;
  logic [5:0]  psl_cfg_q;
  logic [5:0]  psl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= RATE_RESET;
      chan_q    <= CHANNEL_RESET;
      psl_cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_RATE: rate_q    <= cfg_data_i;
        CFG_CHANNEL:     chan_q    <= cfg_data_i[2:0];
        CFG_PS_LENGTH:   psl_cfg_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign psl = (psl_cfg_q > DEPTH6) ? DEPTH6 : psl_cfg_q;

  // parameter-set store
  logic [7:0] ps_mem [PARAM_SET_DEPTH];
  logic [7:0] ps_rd_q;
  logic [5:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_store && (store_index_i < DEPTH6)) begin
      ps_mem[store_index_i[AW-1:0]] <= data_byte_i;
    end
    if (cmd_i.rd_store) begin
      ps_rd_q <= ps_mem[cnt_q[AW-1:0]];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.latch) begin
      cnt_d = '0;
    end else if ((cmd_i.push_sel == PUSH_PS) || (cmd_i.push_sel == PUSH_ADTS)) begin
      cnt_d = cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // latched item for samples that get a header first
  logic [7:0]  it_byte_q;
  logic        it_first_q, it_last_q, it_video_q;
  logic [12:0] it_size_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      it_byte_q  <= data_byte_i;
      it_first_q <= sample_first_i;
      it_last_q  <= sample_last_i;
      it_video_q <= is_video_i;
      it_size_q  <= sample_size_i;
    end
  end

  logic [7:0] cur_byte;
  logic       cur_first, cur_last, cur_video;

  assign cur_byte  = cmd_i.use_latched ? it_byte_q  : data_byte_i;
  assign cur_first = cmd_i.use_latched ? it_first_q : sample_first_i;
  assign cur_last  = cmd_i.use_latched ? it_last_q  : sample_last_i;
  assign cur_video = cmd_i.use_latched ? it_video_q : is_video_i;

  // prefix parser
  logic [1:0]  pos_q, pos_d;
  logic        inp_q, inp_d;
  logic [23:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  logic [7:0]  body_byte;
  logic        bad;

  always_comb begin
    logic [1:0]  pos;
    logic        ip;
    logic [23:0] acc;
    logic [31:0] rem;
    pos = cur_first ? 2'd0  : pos_q;
    ip  = cur_first ? 1'b1  : inp_q;
    acc = cur_first ? 24'd0 : acc_q;
    rem = cur_first ? 32'd0 : rem_q;
    pos_d = pos;
    inp_d = ip;
    acc_d = acc;
    rem_d = rem;
    body_byte = cur_byte;
    bad = 1'b0;
    if (cur_video) begin
      if (ip) begin
        if (pos != 2'd3) begin
          acc_d     = {acc[15:0], cur_byte};
          pos_d     = pos + 2'd1;
          body_byte = START_ZERO;
        end else begin
          rem_d     = {acc, cur_byte};
          acc_d     = '0;
          pos_d     = 2'd0;
          inp_d     = (rem_d == 32'd0);
          body_byte = START_ONE;
        end
      end else begin
        rem_d = rem - 32'd1;
        if (rem_d == 32'd0) begin
          inp_d = 1'b1;
          pos_d = 2'd0;
        end
      end
      bad = cur_last && !(inp_d && (pos_d == 2'd0));
    end
    if (cur_last) begin
      pos_d = 2'd0;
      inp_d = 1'b1;
      acc_d = '0;
      rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      inp_q <= 1'b1;
      acc_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.push_sel == PUSH_BODY) begin
      pos_q <= pos_d;
      inp_q <= inp_d;
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  // output register
  logic        out_valid_q;
  logic [7:0]  obyte_d;
  logic [12:0] flen;

  assign flen = it_size_q + ADTS_EXTRA;

  always_comb begin
    unique case (cmd_i.push_sel)
      PUSH_PS:   obyte_d = ps_rd_q;
      PUSH_ADTS: obyte_d = adts_byte(cnt_q[2:0], rate_index(rate_q), chan_q, flen);
      PUSH_BODY: obyte_d = body_byte;
      default:   obyte_d = body_byte;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_sel != PUSH_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_sel != PUSH_NONE) begin
      out_byte_o    <= obyte_d;
      run_last_o    <= (cmd_i.push_sel == PUSH_BODY);
      sample_done_o <= (cmd_i.push_sel == PUSH_BODY) && cur_last;
      malformed_o   <= (cmd_i.push_sel == PUSH_BODY) && bad;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.in_op      = op_i;
  assign sts_o.in_first   = sample_first_i;
  assign sts_o.in_video   = is_video_i;
  assign sts_o.in_key     = is_key_i;
  assign sts_o.ps_empty   = (psl == 6'd0);
  assign sts_o.ps_at_end  = (cnt_q == psl - 6'd1);
  assign sts_o.hdr_at_end = (cnt_q == ADTS_LEN - 6'd1);
  assign sts_o.slot_free  = !out_valid_q || !out_stall_i;

endmodule

### rtl/core/avcc_adts_elementary_framer_top.sv
// Top level of the AVCC to Annex B / AAC ADTS elementary stream framer.
// Each transfer's result goes to the output register; a first byte with a header is held
// and leaves after the header (ADTS for audio, the stored parameter set for key video).
// Throughput: one byte per cycle outside header insertion; output stalls hold the
// input (single output register). Reset (async, active low) clears sequencer, parser,
// counter, output valid and config to defaults; the store is not cleared.
module avcc_adts_elementary_framer_top
  import aaef_pkg::*;
#(
  parameter int PARAM_SET_DEPTH = PS_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  store_index_i,
  input  logic        sample_first_i,
  input  logic        sample_last_i,
  input  logic        is_video_i,
  input  logic        is_key_i,
  input  logic [12:0] sample_size_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        sample_done_o,
  output logic        malformed_o
);

  aaef_cmd_t cmd;
  aaef_sts_t sts;

  // Sequencer: only idle state takes new transfers; header bytes are
  // pushed one per free output slot, then the held payload byte.
  aaef_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Datapath: store, ADTS builder, length-prefix parser and the single
  // output register that decouples both channels.
  aaef_dp #(
    .PARAM_SET_DEPTH (PARAM_SET_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .store_index_i  (store_index_i),
    .sample_first_i (sample_first_i),
    .sample_last_i  (sample_last_i),
    .is_video_i     (is_video_i),
    .is_key_i       (is_key_i),
    .sample_size_i  (sample_size_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .sample_done_o  (sample_done_o),
    .malformed_o    (malformed_o)
  );

`ifndef SYNTHESIS
  // a push never overwrites a result that is still waiting
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push_sel != PUSH_NONE) |-> sts.slot_free)
    else $error("push into occupied output register");

  // the sample-ending byte is always the last result of its transfer
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_done_o) |-> run_last_o)
    else $error("sample_done without run_last");

  a_bad_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && malformed_o) |-> sample_done_o)
    else $error("malformed outside sample end");

  // an audio first byte must hold off the next transfer for its header
  a_adts_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !op_i && sample_first_i && !is_video_i) |=> in_stall_o)
    else $error("transfer taken during ADTS header");
`endif

endmodule

### tb/sv/aaef_tb_pkg.sv
// Transfer types and the expected-stream scoreboard of the elementary stream framer bench.
`timescale 1ns / 1ps
package aaef_tb_pkg;
  import aaef_pkg::*;

  localparam int STORE_DEPTH = PS_DEPTH_DEF;
  localparam int MAX_REPORTS = 40;

  localparam logic [7:0] ADTS_SYNC    = 8'hFF;
  localparam logic [7:0] ADTS_ID      = 8'hF1;
  localparam logic [7:0] ADTS_LC_BASE = 8'h40;
  localparam logic [7:0] ADTS_FULL_LO = 8'h1F;
  localparam logic [7:0] ADTS_TAIL    = 8'hFC;

  // rate table position is the ADTS frequency index
  localparam int unsigned ADTS_RATES [13] = '{96000, 88200, 64000, 48000, 44100, 32000,
                                              24000, 22050, 16000, 12000, 11025, 8000, 7350};

  typedef struct packed {
    logic        op;
    logic [7:0]  data_byte;
    logic [5:0]  store_index;
    logic        sample_first;
    logic        sample_last;
    logic        is_video;
    logic        is_key;
    logic [12:0] sample_size;
  } framer_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       sample_done;
    logic       malformed;
  } stream_byte_t;

  class stream_scoreboard;
    logic [16:0]  rate_hz;
    logic [2:0]   chan_cfg;
    logic [5:0]   ps_len;
    logic [7:0]   ps_store [STORE_DEPTH];
    logic [1:0]   pfx_pos;
    logic         in_pfx;
    logic [23:0]  len_acc;
    logic [31:0]  body_left;
    stream_byte_t expected_bytes [$];
    int unsigned  fail_count;

    function new();
      rate_hz    = RATE_RESET;
      chan_cfg   = CHANNEL_RESET;
      ps_len     = '0;
      fail_count = 0;
      foreach (ps_store[i]) ps_store[i] = '0;
      clear_parser();
    endfunction

    function void clear_parser();
      pfx_pos   = '0;
      in_pfx    = 1'b1;
      len_acc   = '0;
      body_left = '0;
    endfunction

    function logic [3:0] freq_index(logic [16:0] hz);
      for (int i = 0; i < 13; i++) begin
        if (hz == ADTS_RATES[i]) return 4'(i);
      end
      return 4'd0;
    endfunction

    function void write_cfg(logic [1:0] idx, logic [16:0] value);
      case (idx)
        CFG_SAMPLE_RATE: rate_hz  = value;
        CFG_CHANNEL:     chan_cfg = value[2:0];
        CFG_PS_LENGTH:   ps_len   = value[5:0];
        default: ;
      endcase
    endfunction

    // Works out the bytes one accepted transfer puts on the output.
    function void predict_stream(framer_item_t it);
      logic [7:0]   run [$];
      logic [12:0]  flen;
      logic [3:0]   fi;
      logic         bad;
      stream_byte_t eb;
      bad = 1'b0;
      if (it.op == OP_LOAD) begin
        if (it.store_index < STORE_DEPTH) ps_store[it.store_index] = it.data_byte;
        return;
      end
      if (it.sample_first) begin
        clear_parser();
        if (it.is_video && it.is_key) begin
          for (int i = 0; i < ps_len && i < STORE_DEPTH; i++) run.push_back(ps_store[i]);
        end else if (!it.is_video) begin
          flen = it.sample_size + ADTS_EXTRA;
          fi   = freq_index(rate_hz);
          run.push_back(ADTS_SYNC);
          run.push_back(ADTS_ID);
          run.push_back(ADTS_LC_BASE | (8'(fi) << 2) | 8'(chan_cfg >> 2));
          run.push_back({chan_cfg[1:0], 6'd0} | 8'(flen >> 11));
          run.push_back(flen[10:3]);
          run.push_back({flen[2:0], 5'd0} | ADTS_FULL_LO);
          run.push_back(ADTS_TAIL);
        end
      end
      if (it.is_video) begin
        if (in_pfx) begin
          if (pfx_pos < 2'd3) begin
            len_acc = {len_acc[15:0], it.data_byte};
            pfx_pos = pfx_pos + 2'd1;
            run.push_back(START_ZERO);
          end else begin
            body_left = {len_acc, it.data_byte};
            len_acc   = '0;
            pfx_pos   = '0;
            in_pfx    = (body_left == 0);
            run.push_back(START_ONE);
          end
        end else begin
          run.push_back(it.data_byte);
          body_left = body_left - 1;
          if (body_left == 0) begin
            in_pfx  = 1'b1;
            pfx_pos = '0;
          end
        end
        if (it.sample_last && !(in_pfx && pfx_pos == 0)) bad = 1'b1;
      end else begin
        run.push_back(it.data_byte);
      end
      foreach (run[k]) begin
        eb.out_byte    = run[k];
        eb.run_last    = (k == run.size() - 1);
        eb.sample_done = eb.run_last && it.sample_last;
        eb.malformed   = eb.sample_done && bad;
        expected_bytes.push_back(eb);
      end
      if (it.sample_last) clear_parser();
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      if (fail_count < MAX_REPORTS) $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    endfunction

    function void check_byte(stream_byte_t got);
      stream_byte_t want;
      if (expected_bytes.size() == 0) begin
        if (fail_count < MAX_REPORTS) $error("out_byte 0x%0h with nothing expected", got.out_byte);
        fail_count++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
      if (got.run_last !== want.run_last) report("run_last", want.run_last, got.run_last);
      if (got.sample_done !== want.sample_done) begin
        report("sample_done", want.sample_done, got.sample_done);
      end
      if (got.malformed !== want.malformed) report("malformed", want.malformed, got.malformed);
    endfunction
  endclass

endpackage

### tb/sv/avcc_adts_elementary_framer_top_tb.sv
// Self-checking bench for the AVCC / ADTS elementary stream framer top level.
`timescale 1ns / 1ps
module avcc_adts_elementary_framer_top_tb;
  import aaef_pkg::*;
  import aaef_tb_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 10;   // a store write has no output; covers its write cycle
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 6;
  localparam int PS_FILL       = 16;   // store entries loaded before any key frame reads them

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [16:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        op_i;
  logic [7:0]  data_byte_i;
  logic [5:0]  store_index_i;
  logic        sample_first_i;
  logic        sample_last_i;
  logic        is_video_i;
  logic        is_key_i;
  logic [12:0] sample_size_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        sample_done_o;
  logic        malformed_o;

  stream_scoreboard sb;

  framer_item_t item_now;
  stream_byte_t byte_now;

  int idle_level = 0;    // 0: no idling; higher: more gaps and stalls
  int hold_left  = 0;
  int burst_left = 0;
  logic hold_req = 1'b0;
  int items_sent = 0;
  int cycle_count = 0;

  avcc_adts_elementary_framer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .store_index_i  (store_index_i),
    .sample_first_i (sample_first_i),
    .sample_last_i  (sample_last_i),
    .is_video_i     (is_video_i),
    .is_key_i       (is_key_i),
    .sample_size_i  (sample_size_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .sample_done_o  (sample_done_o),
    .malformed_o    (malformed_o)
  );

  assign item_now = {op_i, data_byte_i, store_index_i, sample_first_i, sample_last_i,
                     is_video_i, is_key_i, sample_size_i};
  assign byte_now = {out_byte_o, run_last_o, sample_done_o, malformed_o};

  always #CLK_HALF clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Monitor. Everything is driven with NBAs at the rising edge, so the values seen here
  // are the ones the block saw at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_cfg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.predict_stream(item_now);
      if (out_valid_o && !out_stall_i) sb.check_byte(byte_now);
    end
  end

  // Receiver. A hold request starts one long stall stretch, counted here; otherwise
  // stalls come in random bursts, as dense as idle_level says.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left   <= LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left  <= burst_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_level != 0 && $urandom_range(0, 9) < idle_level) begin
      burst_left  <= $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // One transfer on the input channel, with an optional idle gap in front of it.
  // Valid is only dropped when a gap follows, so it never toggles within a step.
  task automatic send_item(input framer_item_t it);
    int gap;
    gap = 0;
    if (idle_level != 0 && $urandom_range(0, 9) < idle_level) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    {op_i, data_byte_i, store_index_i, sample_first_i, sample_last_i,
     is_video_i, is_key_i, sample_size_i} <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Store write; the unused fields carry noise the block must ignore.
  task automatic send_load(input logic [5:0] idx, input logic [7:0] value);
    framer_item_t it;
    it             = framer_item_t'($urandom);
    it.op          = OP_LOAD;
    it.data_byte   = value;
    it.store_index = idx;
    it.sample_size = 13'($urandom_range(0, 8184));
    send_item(it);
  endtask

  task automatic send_payload(input logic [7:0] value, input logic first, input logic fin,
                              input logic video, input logic key, input logic [12:0] size);
    framer_item_t it;
    it.op           = OP_PAYLOAD;
    it.data_byte    = value;
    it.store_index  = 6'($urandom_range(0, STORE_DEPTH - 1));
    it.sample_first = first;
    it.sample_last  = fin;
    it.is_video     = video;
    it.is_key       = key;
    it.sample_size  = size;
    send_item(it);
  endtask

  // A whole sample: first flag on byte 0, last flag on the final byte. The key flag
  // only counts on the first byte, so later bytes get a random one.
  task automatic send_sample(input logic [7:0] bytes [$], input logic video,
                             input logic key, input logic [12:0] size);
    foreach (bytes[i]) begin
      send_payload(bytes[i], i == 0, i == bytes.size() - 1, video,
                   (i == 0) ? key : 1'($urandom),
                   (i == 0) ? size : 13'($urandom_range(0, 8184)));
    end
  endtask

  // Length-prefixed video sample of 1 to 3 NALs, mostly short. A broken one is cut
  // short, sometimes after an absurd length prefix, so it may end inside a prefix or body.
  task automatic send_video(input logic key, input logic broken);
    logic [7:0]  pkt [$];
    logic [31:0] nal_len;
    int          cut;
    repeat ($urandom_range(1, 3)) begin
      nal_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      pkt.push_back(nal_len[31:24]);
      pkt.push_back(nal_len[23:16]);
      pkt.push_back(nal_len[15:8]);
      pkt.push_back(nal_len[7:0]);
      repeat (nal_len) pkt.push_back(8'($urandom));
    end
    if (broken) begin
      if ($urandom_range(0, 1) == 0) pkt[0] = 8'($urandom);
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    send_sample(pkt, 1'b1, key, 13'($urandom_range(0, 8184)));
  endtask

  // Raw AAC sample; the size field usually matches the payload, sometimes not.
  task automatic send_audio();
    logic [7:0]  pkt [$];
    logic [12:0] sz;
    int          n;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    repeat (n) pkt.push_back(8'($urandom));
    sz = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8184)) : 13'(n);
    send_sample(pkt, 1'b0, 1'($urandom), sz);
  endtask

  // Arbitrary payload transfer: any mix of flags, parser picks up from where it is.
  task automatic send_noise();
    framer_item_t it;
    it             = framer_item_t'($urandom);
    it.op          = OP_PAYLOAD;
    it.store_index = 6'($urandom_range(0, STORE_DEPTH - 1));
    it.sample_size = 13'($urandom_range(0, 8184));
    send_item(it);
  endtask

  // Wait for the block to go quiet. The first edge lets the monitor see the last
  // transfer; the extra cycles cover a store write that produces no output.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // All three registers, one per edge; only called while the block is idle.
  task automatic write_config(input logic [16:0] hz, input logic [2:0] ch,
                              input logic [5:0] plen);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SAMPLE_RATE;
    cfg_data_i  <= hz;
    @(posedge clk_i);
    cfg_index_i <= CFG_CHANNEL;
    cfg_data_i  <= {14'd0, ch};
    @(posedge clk_i);
    cfg_index_i <= CFG_PS_LENGTH;
    cfg_data_i  <= {11'd0, plen};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [7:0]  pkt [$];
    logic [16:0] phase_rate [PHASES];
    logic [2:0]  phase_chan [PHASES];
    logic [5:0]  plen;
    int          start_count;
    int          pick;

    // rates: top of table, bottom of table, zero and an off-table value (both unknown)
    phase_rate = '{17'd96000, 17'd7350, 17'd0, 17'd12345, 17'd48000, 17'd22050, 17'd44100};
    phase_chan = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2};

    sb             = new();
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_SAMPLE_RATE;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    op_i           = OP_PAYLOAD;
    data_byte_i    = '0;
    store_index_i  = '0;
    sample_first_i = 1'b0;
    sample_last_i  = 1'b0;
    is_video_i     = 1'b0;
    is_key_i       = 1'b0;
    sample_size_i  = '0;
    idle_level     = 2;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part, reset configuration (parameter-set length zero) ----
    // store writes at both ends of the index range, extreme data
    send_load(6'd0, 8'h00);
    send_load(6'(STORE_DEPTH - 1), 8'hFF);
    // one-byte audio sample of size zero, with a stray key flag
    pkt = '{8'hFF};
    send_sample(pkt, 1'b0, 1'b1, 13'd0);
    // size at the top of the 13-bit field: the frame length wraps
    pkt = '{8'h00, 8'h7E};
    send_sample(pkt, 1'b0, 1'b0, 13'h1FFF);
    // key frame: empty NAL directly followed by a one-byte NAL
    pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hAA};
    send_sample(pkt, 1'b1, 1'b1, 13'd0);
    // sample ends halfway through a length prefix
    pkt = '{8'h00, 8'h00};
    send_sample(pkt, 1'b1, 1'b0, 13'd0);
    // sample ends inside a NAL body
    pkt = '{8'h00, 8'h00, 8'h00, 8'h05, 8'hAB};
    send_sample(pkt, 1'b1, 1'b0, 13'd0);
    // a sample left open, then a first byte that must restart the prefix parser
    send_payload(8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 13'd0);
    pkt = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_sample(pkt, 1'b1, 1'b0, 13'd0);

    // ---- Fill the front of the parameter-set store; every length used below fits ----
    for (int i = 0; i < PS_FILL; i++) send_load(6'(i), 8'($urandom));

    // ---- Random part, one configuration per phase ----
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) plen = 6'(PS_FILL);
      else if (p == 1) plen = 6'd0;
      else plen = 6'($urandom_range(1, PS_FILL));
      write_config(phase_rate[p], phase_chan[p], plen);
      // the closing phase runs at full rate on both sides
      idle_level <= (p == PHASES - 1) ? 0 : $urandom_range(0, 3);
      if (p == 2) begin
        // long receiver hold-off while the sender keeps offering: the block backs up
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) send_video(1'($urandom), 1'b0);
        else if (pick < 65) send_audio();
        else if (pick < 78) send_video(1'($urandom), 1'b1);
        else if (pick < 90) send_noise();
        else send_load(6'($urandom_range(0, STORE_DEPTH - 1)), 8'($urandom));
      end
    end

    // ---- Drain and verdict ----
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
